// ===== rtl/core/gcl_pkg.sv =====
// shared types and constants for the grid cell locator
`default_nettype none

package gcl_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int WIDTH_W = 31;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;
    // doubled-scale edge values: 2*c +/- w fits in two extra bits
    localparam int EDGE_W  = COORD_W + 2;
    // one table row holds the centre and the width
    localparam int ROW_W   = COORD_W + WIDTH_W;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [IDX_W-1:0]          entry_index;
        logic signed [COORD_W-1:0] entry_center;
        logic [WIDTH_W-1:0]        entry_width;
        logic signed [COORD_W-1:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic             in_range;
        logic [IDX_W-1:0] cell_index;
    } t_out_item;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } t_op_kind;

    // classified request passed from the front queue to the back end
    typedef struct packed {
        t_op_kind                  kind;
        logic [IDX_W-1:0]          entry_index;
        logic signed [COORD_W-1:0] entry_center;
        logic [WIDTH_W-1:0]        entry_width;
        logic signed [COORD_W-1:0] query_value;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOWER,
        B_UPPER,
        B_SEARCH,
        B_FINAL,
        B_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/gcl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module gcl_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/gcl_front.sv =====
// front end: accepts requests, classifies them and queues them for the back end
`default_nettype none

module gcl_front
    import gcl_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_pop
);

    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_job       r_slot [2];

    t_job job_in;
    logic drop;
    logic push;

    // classify the incoming request
    always_comb begin
        job_in.kind         = (i_in_item.command == CMD_LOAD) ? OP_LOAD : OP_QUERY;
        job_in.entry_index  = i_in_item.entry_index;
        job_in.entry_center = i_in_item.entry_center;
        job_in.entry_width  = i_in_item.entry_width;
        job_in.query_value  = i_in_item.query_value;
    end

    // loads past the end of the table are taken and dropped
    assign drop = (job_in.kind == OP_LOAD) &&
                  ({1'b0, i_in_item.entry_index} >= COUNT_W'(DEPTH));

    assign o_in_ready  = (r_count != 2'd2);
    assign push        = i_in_valid && o_in_ready && !drop;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_slot[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= job_in;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_job_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_job_pop};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gcl_back.sv =====
// back end: writes table rows and runs the range check and binary search
`default_nettype none

module gcl_back
    import gcl_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    input  wire t_job               i_job,
    output logic                    o_job_pop,
    input  wire logic [COUNT_W-1:0] i_cell_count,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item
);

    localparam int AW = $clog2(DEPTH);

    t_back_state               r_state, n_state;
    logic signed [COORD_W-1:0] r_value, n_value;
    logic [COUNT_W-1:0]        r_n, n_n;
    logic [AW-1:0]             r_lo, n_lo;
    logic [AW-1:0]             r_hi, n_hi;
    logic [AW-1:0]             r_mid, n_mid;
    logic                      r_in_range, n_in_range;
    logic [IDX_W-1:0]          r_cell_index, n_cell_index;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_item, n_out_item;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [ROW_W-1:0]          ram_rdata;

    logic signed [COORD_W-1:0] rd_center;
    logic [WIDTH_W-1:0]        rd_width;
    logic signed [EDGE_W-1:0]  c2, w_ext, lower2, upper2, v2;
    logic [COUNT_W-1:0]        count_clamped;
    logic                      out_free;
    logic                      go_right;
    logic [AW-1:0]             step_lo, step_hi;
    logic [AW:0]               step_sum, up_sum, lo_next;
    logic [AW:0]               found;

    gcl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // row decode and doubled-scale edges
    assign rd_center = ram_rdata[ROW_W-1:WIDTH_W];
    assign rd_width  = ram_rdata[WIDTH_W-1:0];
    assign c2        = {rd_center[COORD_W-1], rd_center, 1'b0};
    assign w_ext     = {3'b000, rd_width};
    assign lower2    = c2 - w_ext;
    assign upper2    = c2 + w_ext;
    assign v2        = {r_value[COORD_W-1], r_value, 1'b0};

    // counts above the table size are treated as the table size
    assign count_clamped = (i_cell_count > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH)
                                                            : i_cell_count;
    assign out_free = !r_out_valid || i_out_ready;

    // one search step on the row at r_mid
    assign go_right = (rd_center <= r_value);
    assign step_lo  = go_right ? r_mid : r_lo;
    assign step_hi  = go_right ? r_hi : r_mid - AW'(1);
    assign step_sum = {1'b0, step_lo} + {1'b0, step_hi} + (AW+1)'(1);
    // first probe after the range check: lo is 0, hi is n-1, so lo+hi+1 = n
    assign up_sum   = (AW+1)'(r_n);
    assign lo_next  = {1'b0, r_lo} + (AW+1)'(1);
    assign found    = ((v2 >= upper2) && (COUNT_W'(lo_next) < r_n)) ? lo_next
                                                                   : {1'b0, r_lo};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid && i_job.kind == OP_QUERY) begin
                    n_state = (count_clamped == '0) ? B_DONE : B_LOWER;
                end
            end
            B_LOWER: begin
                n_state = (v2 < lower2) ? B_DONE : B_UPPER;
            end
            B_UPPER: begin
                if (v2 > upper2) begin
                    n_state = B_DONE;
                end else if (r_n == COUNT_W'(1)) begin
                    n_state = B_FINAL;
                end else begin
                    n_state = B_SEARCH;
                end
            end
            B_SEARCH: begin
                if (step_lo >= step_hi) begin
                    n_state = B_FINAL;
                end
            end
            B_FINAL: begin
                n_state = B_DONE;
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        o_job_pop    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = AW'(i_job.entry_index);
        ram_wdata    = {i_job.entry_center, i_job.entry_width};
        ram_raddr    = '0;
        n_value      = r_value;
        n_n          = r_n;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_in_range   = r_in_range;
        n_cell_index = r_cell_index;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_item   = r_out_item;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (i_job.kind == OP_LOAD) begin
                        ram_we = 1'b1;
                    end else begin
                        n_value      = i_job.query_value;
                        n_n          = count_clamped;
                        n_in_range   = 1'b0;
                        n_cell_index = '0;
                        ram_raddr    = '0;
                    end
                end
            end
            B_LOWER: begin
                ram_raddr = AW'(r_n - COUNT_W'(1));
            end
            B_UPPER: begin
                n_lo  = '0;
                n_hi  = AW'(r_n - COUNT_W'(1));
                n_mid = up_sum[AW:1];
                if (r_n == COUNT_W'(1)) begin
                    ram_raddr = '0;
                end else begin
                    ram_raddr = up_sum[AW:1];
                end
            end
            B_SEARCH: begin
                n_lo  = step_lo;
                n_hi  = step_hi;
                n_mid = step_sum[AW:1];
                if (step_lo < step_hi) begin
                    ram_raddr = step_sum[AW:1];
                end else begin
                    ram_raddr = step_lo;
                end
            end
            B_FINAL: begin
                n_in_range   = 1'b1;
                n_cell_index = IDX_W'(found);
            end
            B_DONE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.in_range   = r_in_range;
                    n_out_item.cell_index = r_cell_index;
                end
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_n          <= n_n;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_in_range   <= n_in_range;
        r_cell_index <= n_cell_index;
        r_out_item   <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/core/grid_cell_locator.sv =====
// grid cell locator top level: config register, request queue and search back end
// a load writes its table row in the cycle the back end takes it; a query reads one
// table row per step of its range check and binary search
// queries run one at a time: the back end takes a load every cycle while no query is
// in progress; a two-entry queue lets requests arrive meanwhile
// reset clears the control state and cell_count to 0; table contents stay undefined
`default_nettype none

module grid_cell_locator
    import gcl_pkg::*;
#(
    parameter int MAX_CELLS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata
);

    // rows addressable by the 8-bit entry index
    localparam int DEPTH = (MAX_CELLS < (1 << IDX_W)) ? MAX_CELLS : (1 << IDX_W);

    logic [COUNT_W-1:0] r_cell_count;
    logic               w_job_valid;
    t_job               w_job;
    logic               w_job_pop;

    // cell count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= '0;
        end else if (i_cfg_we) begin
            r_cell_count <= i_cfg_wdata;
        end
    end

    gcl_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    gcl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job),
        .o_job_pop    (w_job_pop),
        .i_cell_count (r_cell_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

    // back end only takes a request the queue holds
    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> w_job_valid)
        else $error("request popped from empty queue");

    // an out-of-range result carries cell index zero
    a_oor_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.in_range) |-> (o_out_item.cell_index == '0))
        else $error("out-of-range result with nonzero cell index");

    // a located cell lies within the cells in use
    a_index_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.in_range) |->
            ({1'b0, o_out_item.cell_index} < r_cell_count))
        else $error("located cell index beyond cell count");

endmodule

`default_nettype wire
